FILE: rtl/i2cm_pkg.sv
// Shared types and constants for the I2C byte transfer master.
// No dependencies; imported by the top level and the send-buffer RAM.
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int BUFFER_DEPTH_DEFAULT = 16;
    localparam logic [7:0] HALF_PERIOD_RESET = 8'd5;
    localparam int BYTE_COUNT_MAX = 16;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    typedef enum logic [9:0] {
        PH_IDLE     = 10'b00_0000_0001,
        PH_START    = 10'b00_0000_0010,
        PH_ADDR     = 10'b00_0000_0100,
        PH_AACK     = 10'b00_0000_1000,
        PH_WDATA    = 10'b00_0001_0000,
        PH_WACK     = 10'b00_0010_0000,
        PH_RDATA    = 10'b00_0100_0000,
        PH_MACK     = 10'b00_1000_0000,
        PH_STOP     = 10'b01_0000_0000,
        PH_STOP_REL = 10'b10_0000_0000
    } phase_t;

endpackage

FILE: rtl/i2cm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on i2cm_pkg for its default depth.
`timescale 1ns / 1ps

module i2cm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = i2cm_pkg::BUFFER_DEPTH_DEFAULT,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    import i2cm_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/i2c_master_byte_transfer.sv
// I2C byte transfer master: bus timing state machine, one input item per tick.
// Depends on i2cm_pkg and i2cm_ram (send buffer).
//
// Usage:
//   s_ channel: one item per bus tick. s_tuser carries the action (tick, load
//   a send-buffer slot, start write, start read); s_tdata carries address,
//   byte count, load slot/byte and the sampled SDA level. Actions other than
//   tick are honored only while idle.
//   m_ channel: exactly one result item per input item: SCL/SDA drive, busy,
//   NACK error, received byte with its index (m_tuser flags it valid), and
//   m_tlast on the tick the STOP completes.
//   cfg_wr_en/cfg_wr_data write half_period_ticks; write it only while idle.
//   Output: the result of an item is registered when the item is accepted.
//   Throughput: one item per cycle unless a waiting result stalls it; the
//   state update and the result are formed in one pass of logic from the
//   state registers. The send buffer RAM is read ahead of the slot it will need.
//   Stall: while m_tready is low and a result waits, s_tready drops and the
//   state holds; no item is lost. Reset (aresetn low, synchronous) returns to
//   idle with both lines released; buffer contents are kept as they are.
`timescale 1ns / 1ps

module i2c_master_byte_transfer #(
    parameter int BUFFER_DEPTH = i2cm_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] address_byte, [12:8] byte_count, [16:13] load_index,
    // [24:17] load_byte, [25] sda_in, [31:26] zero
    input  logic [31:0] s_tdata,
    // [1:0] action
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] scl_out, [1] sda_out, [2] busy_res, [3] nack_error,
    // [11:4] rx_byte, [15:12] rx_index
    output logic [15:0] m_tdata,
    // [0] rx_valid
    output logic [0:0]  m_tuser,
    // done_res
    output logic        m_tlast
);
    import i2cm_pkg::*;

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    // input fields
    action_t    action;
    logic [7:0] address_byte;
    logic [4:0] byte_count;
    logic [3:0] load_index;
    logic [7:0] load_byte;
    logic       sda_in;

    assign action       = action_t'(s_tuser);
    assign address_byte = s_tdata[7:0];
    assign byte_count   = s_tdata[12:8];
    assign load_index   = s_tdata[16:13];
    assign load_byte    = s_tdata[24:17];
    assign sda_in       = s_tdata[25];

    logic [7:0] half_period_reg;

    phase_t     phase_reg, phase_next;
    logic [7:0] tick_reg, tick_next;
    logic [3:0] bit_reg, bit_next;
    logic [4:0] pos_reg, pos_next;
    logic [4:0] left_reg, left_next;
    logic [7:0] shift_reg, shift_next;
    logic       reading_reg, reading_next;
    logic       error_reg, error_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;

    logic       out_valid_reg;
    logic [15:0] out_data_reg;
    logic       out_rxv_reg;
    logic       out_done_reg;

    logic       accept;
    logic       rx_valid_c;
    logic [7:0] rx_byte_c;
    logic [3:0] rx_index_c;
    logic       done_c;

    logic          buf_we;
    logic [8:0]    wr_pos_x;
    logic [AW-1:0] buf_waddr;
    logic [4:0]    look_pos;
    logic [8:0]    look_pos_x;
    logic [AW-1:0] buf_raddr;
    logic [7:0]    buf_rdata;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // half-period lengths
    logic [7:0] high_len, low_len;
    assign high_len = (half_period_reg < 8'd1) ? 8'd1 : half_period_reg;
    assign low_len  = (half_period_reg < 8'd2) ? 8'd2 : half_period_reg;

    always_comb begin
        logic [7:0] tick_inc;
        logic [3:0] bit_inc;
        logic       go_next;
        logic [4:0] left_new;
        logic [4:0] pos_new;
        logic       cell_val;

        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_next     = bit_reg;
        pos_next     = pos_reg;
        left_next    = left_reg;
        shift_next   = shift_reg;
        reading_next = reading_reg;
        error_next   = error_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        rx_valid_c   = 1'b0;
        rx_byte_c    = 8'd0;
        rx_index_c   = 4'd0;
        done_c       = 1'b0;
        buf_we       = 1'b0;

        tick_inc = (tick_reg == 8'hff) ? tick_reg : tick_reg + 8'd1;
        bit_inc  = bit_reg + 4'd1;
        go_next  = 1'b0;
        left_new = left_reg;
        pos_new  = pos_reg;

        unique case (phase_reg)
            PH_ADDR, PH_WDATA: cell_val = shift_reg[7];
            PH_MACK:           cell_val = (left_reg <= 5'd1);
            PH_STOP:           cell_val = 1'b0;
            default:           cell_val = 1'b1;
        endcase

        if (phase_reg == PH_IDLE) begin
            if (action == ACT_LOAD) begin
                buf_we = ({28'd0, load_index} < 32'(BUFFER_DEPTH));
            end else if (action == ACT_WRITE || action == ACT_READ) begin
                left_next    = (byte_count > 5'(BYTE_COUNT_MAX))
                             ? 5'(BYTE_COUNT_MAX) : byte_count;
                pos_next     = 5'd0;
                reading_next = (action == ACT_READ);
                error_next   = 1'b0;
                shift_next   = address_byte;
                bit_next     = 4'd0;
                scl_next     = 1'b1;
                sda_next     = 1'b0;
                phase_next   = PH_START;
                tick_next    = 8'd0;
            end
        end else begin
            tick_next = tick_inc;
            if (phase_reg == PH_START) begin
                if (tick_inc >= high_len) begin
                    bit_next   = 4'd0;
                    phase_next = PH_ADDR;
                    scl_next   = 1'b0;
                    tick_next  = 8'd0;
                end
            end else if (phase_reg == PH_STOP_REL) begin
                if (tick_inc >= high_len) begin
                    phase_next = PH_IDLE;
                    tick_next  = 8'd0;
                    done_c     = 1'b1;
                end
            end else if (!scl_reg) begin
                // SDA moves only inside the low half
                sda_next = cell_val;
                if (tick_inc >= low_len) begin
                    scl_next  = 1'b1;
                    tick_next = 8'd0;
                end
            end else if (tick_inc >= high_len) begin
                // end of a bit cell; sda_in sampled on the last high tick
                unique case (phase_reg)
                    PH_ADDR, PH_WDATA: begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        bit_next   = bit_inc;
                        scl_next   = 1'b0;
                        tick_next  = 8'd0;
                        if (bit_inc >= 4'd8) begin
                            phase_next = (phase_reg == PH_ADDR) ? PH_AACK : PH_WACK;
                        end
                    end
                    PH_AACK: begin
                        if (sda_in) begin
                            error_next = 1'b1;
                            phase_next = PH_STOP;
                            scl_next   = 1'b0;
                            tick_next  = 8'd0;
                        end else begin
                            go_next = 1'b1;
                        end
                    end
                    PH_WACK: begin
                        if (sda_in) begin
                            error_next = 1'b1;
                            phase_next = PH_STOP;
                            scl_next   = 1'b0;
                            tick_next  = 8'd0;
                        end else begin
                            pos_new  = pos_reg + 5'd1;
                            left_new = (left_reg != 5'd0) ? left_reg - 5'd1 : left_reg;
                            go_next  = 1'b1;
                        end
                    end
                    PH_RDATA: begin
                        shift_next = {shift_reg[6:0], sda_in};
                        bit_next   = bit_inc;
                        scl_next   = 1'b0;
                        tick_next  = 8'd0;
                        if (bit_inc >= 4'd8) begin
                            rx_valid_c = 1'b1;
                            rx_byte_c  = {shift_reg[6:0], sda_in};
                            rx_index_c = pos_reg[3:0];
                            phase_next = PH_MACK;
                        end
                    end
                    PH_MACK: begin
                        pos_new  = pos_reg + 5'd1;
                        left_new = (left_reg != 5'd0) ? left_reg - 5'd1 : left_reg;
                        go_next  = 1'b1;
                    end
                    PH_STOP: begin
                        // release SDA while SCL is high
                        sda_next   = 1'b1;
                        phase_next = PH_STOP_REL;
                        tick_next  = 8'd0;
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (go_next) begin
            pos_next  = pos_new;
            left_next = left_new;
            scl_next  = 1'b0;
            tick_next = 8'd0;
            bit_next  = 4'd0;
            if (left_new == 5'd0) begin
                phase_next = PH_STOP;
            end else if (reading_reg) begin
                shift_next = 8'd0;
                phase_next = PH_RDATA;
            end else begin
                shift_next = ({27'd0, pos_new} < 32'(BUFFER_DEPTH)) ? buf_rdata : 8'd0;
                phase_next = PH_WDATA;
            end
        end

        if (!accept) begin
            phase_next   = phase_reg;
            tick_next    = tick_reg;
            bit_next     = bit_reg;
            pos_next     = pos_reg;
            left_next    = left_reg;
            shift_next   = shift_reg;
            reading_next = reading_reg;
            error_next   = error_reg;
            scl_next     = scl_reg;
            sda_next     = sda_reg;
            buf_we       = 1'b0;
        end
    end

    // The slot needed next: during a write byte it is the following position.
    assign look_pos   = pos_next + ((phase_next == PH_WDATA || phase_next == PH_WACK)
                                    ? 5'd1 : 5'd0);
    assign look_pos_x = 9'(look_pos);
    assign buf_raddr  = look_pos_x[AW-1:0];
    assign wr_pos_x   = 9'(load_index);
    assign buf_waddr  = wr_pos_x[AW-1:0];

    i2cm_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_send_buf (
        .aclk    (aclk),
        .wr_en   (buf_we),
        .wr_addr (buf_waddr),
        .wr_data (load_byte),
        .rd_addr (buf_raddr),
        .rd_data (buf_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RESET;
            phase_reg       <= PH_IDLE;
            tick_reg        <= 8'd0;
            bit_reg         <= 4'd0;
            pos_reg         <= 5'd0;
            left_reg        <= 5'd0;
            shift_reg       <= 8'd0;
            reading_reg     <= 1'b0;
            error_reg       <= 1'b0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                half_period_reg <= cfg_wr_data;
            end
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_reg     <= bit_next;
            pos_reg     <= pos_next;
            left_reg    <= left_next;
            shift_reg   <= shift_next;
            reading_reg <= reading_next;
            error_reg   <= error_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= {rx_index_c, rx_byte_c, error_next,
                             (phase_next != PH_IDLE), sda_next, scl_next};
            out_rxv_reg  <= rx_valid_c;
            out_done_reg <= done_c;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_rxv_reg;
    assign m_tlast    = out_done_reg;

    // SDA moves with SCL high only for START and the release at STOP
    assert property (@(posedge aclk) disable iff (!aresetn)
        (scl_reg && $past(scl_reg) && (sda_reg != $past(sda_reg)))
        |-> (phase_reg == PH_START || phase_reg == PH_STOP_REL))
        else $error("SDA changed while SCL high outside START/STOP");

    // a received byte only comes out of a read transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && rx_valid_c) |-> (reading_reg && phase_reg == PH_RDATA))
        else $error("rx byte outside a read");

    // STOP completion leaves the master idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && done_c) |=> (phase_reg == PH_IDLE && scl_reg && sda_reg))
        else $error("done without returning to idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg <= 5'(BYTE_COUNT_MAX))
        else $error("byte count above limit");

endmodule

FILE: sim/i2c_master_byte_transfer_test.sv
// Self-checking testbench for i2c_master_byte_transfer: directed and random bus traffic,
// with a cycle-accurate bus model predicting every result item. Needs i2cm_pkg and the RTL.
`timescale 1ns / 1ps

module i2c_master_byte_transfer_test;
    import i2cm_pkg::*;

    localparam int ITEM_TARGET    = 850;
    localparam int BUS_TICKS_ALL  = 1 << 30;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       nack;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [3:0] rx_index;
        logic       done;
    } bus_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [7:0] address_byte, [12:8] byte_count, [16:13] load_index,
                            // [24:17] load_byte, [25] sda_in, [31:26] zero
    logic [1:0]  s_tuser;   // [1:0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [0] scl_out, [1] sda_out, [2] busy_res, [3] nack_error,
                            // [11:4] rx_byte, [15:12] rx_index
    logic [0:0]  m_tuser;   // [0] rx_valid
    logic        m_tlast;   // done_res

    // bus model state
    phase_t      bus_phase;
    logic [7:0]  half_period;
    logic [7:0]  hold_ticks;
    logic [3:0]  bits_done;
    logic [4:0]  byte_pos;
    logic [4:0]  bytes_rem;
    logic [7:0]  shifter;
    logic        is_read;
    logic        err_flag;
    logic        scl_drv;
    logic        sda_drv;
    logic [7:0]  tx_buffer [16];

    bus_result_t pending_results[$];
    bus_result_t due;

    int fail_count      = 0;
    int items_sent      = 0;
    int transfers_begun = 0;
    int nack_aborts     = 0;
    int bytes_read      = 0;
    int idle_cycles     = 0;
    bit tx_idle_on      = 1'b1;
    bit rx_idle_on      = 1'b1;

    i2c_master_byte_transfer u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ---------------- bus model ----------------

    function automatic logic [7:0] high_ticks();
        return (half_period < 8'd1) ? 8'd1 : half_period;
    endfunction

    function automatic logic [7:0] low_ticks();
        return (half_period < 8'd2) ? 8'd2 : half_period;
    endfunction

    task automatic begin_bit_cell(input phase_t p);
        bus_phase = p;
        scl_drv = 1'b0;
        hold_ticks = '0;
    endtask

    task automatic advance_byte();
        if (bytes_rem == 0) begin
            begin_bit_cell(PH_STOP);
        end else if (is_read) begin
            shifter = '0;
            bits_done = '0;
            begin_bit_cell(PH_RDATA);
        end else begin
            // byte_pos stays below 16 while bytes remain
            shifter = tx_buffer[byte_pos[3:0]];
            bits_done = '0;
            begin_bit_cell(PH_WDATA);
        end
    endtask

    task automatic predict_bus_tick(input action_t act, input logic [31:0] fields,
                                    output bus_result_t r);
        logic sda_level;
        sda_level = fields[25];
        r = '0;
        if (bus_phase == PH_IDLE) begin
            if (act == ACT_LOAD) begin
                tx_buffer[fields[16:13]] = fields[24:17];
            end else if (act == ACT_WRITE || act == ACT_READ) begin
                bytes_rem = (fields[12:8] > 5'd16) ? 5'd16 : fields[12:8];
                byte_pos = '0;
                is_read = (act == ACT_READ);
                err_flag = 1'b0;
                shifter = fields[7:0];
                bits_done = '0;
                scl_drv = 1'b1;
                sda_drv = 1'b0;
                bus_phase = PH_START;
                hold_ticks = '0;
                transfers_begun++;
            end
        end else begin
            if (hold_ticks != 8'hff)
                hold_ticks++;
            if (bus_phase == PH_START) begin
                if (hold_ticks >= high_ticks()) begin
                    bits_done = '0;
                    begin_bit_cell(PH_ADDR);
                end
            end else if (bus_phase == PH_STOP_REL) begin
                if (hold_ticks >= high_ticks()) begin
                    bus_phase = PH_IDLE;
                    hold_ticks = '0;
                    r.done = 1'b1;
                end
            end else if (!scl_drv) begin
                // SDA moves during the low half only
                case (bus_phase)
                    PH_ADDR, PH_WDATA: sda_drv = shifter[7];
                    PH_MACK:           sda_drv = (bytes_rem <= 1);
                    PH_STOP:           sda_drv = 1'b0;
                    default:           sda_drv = 1'b1;
                endcase
                if (hold_ticks >= low_ticks()) begin
                    scl_drv = 1'b1;
                    hold_ticks = '0;
                end
            end else if (hold_ticks >= high_ticks()) begin
                case (bus_phase)
                    PH_ADDR, PH_WDATA: begin
                        shifter = shifter << 1;
                        bits_done++;
                        if (bits_done >= 8)
                            begin_bit_cell(bus_phase == PH_ADDR ? PH_AACK : PH_WACK);
                        else
                            begin_bit_cell(bus_phase);
                    end
                    PH_AACK: begin
                        if (sda_level) begin
                            err_flag = 1'b1;
                            nack_aborts++;
                            begin_bit_cell(PH_STOP);
                        end else begin
                            advance_byte();
                        end
                    end
                    PH_WACK: begin
                        if (sda_level) begin
                            err_flag = 1'b1;
                            nack_aborts++;
                            begin_bit_cell(PH_STOP);
                        end else begin
                            byte_pos++;
                            if (bytes_rem != 0)
                                bytes_rem--;
                            advance_byte();
                        end
                    end
                    PH_RDATA: begin
                        shifter = {shifter[6:0], sda_level};
                        bits_done++;
                        if (bits_done >= 8) begin
                            r.rx_valid = 1'b1;
                            r.rx_byte = shifter;
                            r.rx_index = byte_pos[3:0];
                            bytes_read++;
                            begin_bit_cell(PH_MACK);
                        end else begin
                            begin_bit_cell(PH_RDATA);
                        end
                    end
                    PH_MACK: begin
                        byte_pos++;
                        if (bytes_rem != 0)
                            bytes_rem--;
                        advance_byte();
                    end
                    default: begin
                        // end of STOP high half: release SDA with SCL high
                        sda_drv = 1'b1;
                        bus_phase = PH_STOP_REL;
                        hold_ticks = '0;
                    end
                endcase
            end
        end
        r.scl = scl_drv;
        r.sda = sda_drv;
        r.busy = (bus_phase != PH_IDLE);
        r.nack = err_flag;
    endtask

    // ---------------- stimulus helpers ----------------

    function automatic logic [31:0] pack_fields(input logic [7:0] addr, input logic [4:0] cnt,
                                                input logic [3:0] slot, input logic [7:0] data,
                                                input logic sda_level);
        return {6'b0, sda_level, data, slot, cnt, addr};
    endfunction

    // slave side: ACK unless a NACK is drawn, random levels elsewhere
    function automatic logic slave_sda(input int addr_nack_pct, input int data_nack_pct);
        if (bus_phase == PH_AACK)
            return $urandom_range(0, 99) < addr_nack_pct;
        if (bus_phase == PH_WACK)
            return $urandom_range(0, 99) < data_nack_pct;
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic send_item(input action_t act, input logic [31:0] fields);
        int gap;
        bus_result_t r;
        gap = tx_idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= fields;
        s_tuser <= act;
        do @(posedge aclk); while (!s_tready);
        predict_bus_tick(act, fields, r);
        pending_results.push_back(r);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_half_period(input logic [7:0] value);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk) cfg_wr_en <= 1'b0;
        half_period = value;
    endtask

    // clock the bus for up to max_ticks items while it is busy
    task automatic clock_bus(input int max_ticks, input int addr_nack_pct,
                             input int data_nack_pct);
        action_t noise;
        int n;
        n = 0;
        while (bus_phase != PH_IDLE && n < max_ticks) begin
            // commands while busy must be ignored
            noise = ($urandom_range(0, 19) == 0) ? action_t'(2'($urandom_range(0, 3)))
                                                 : ACT_TICK;
            send_item(noise, pack_fields(8'($urandom), 5'($urandom), 4'($urandom),
                                         8'($urandom),
                                         slave_sda(addr_nack_pct, data_nack_pct)));
            n++;
        end
    endtask

    // start a transfer from idle and clock the bus until it is idle again
    task automatic run_transfer(input action_t act, input logic [7:0] addr,
                                input logic [4:0] cnt, input int addr_nack_pct,
                                input int data_nack_pct);
        send_item(act, pack_fields(addr, cnt, 4'($urandom), 8'($urandom), 1'($urandom)));
        clock_bus(BUS_TICKS_ALL, addr_nack_pct, data_nack_pct);
    endtask

    task automatic idle_traffic(input int n);
        repeat (n) begin
            send_item(($urandom_range(0, 1) != 0) ? ACT_LOAD : ACT_TICK,
                      pack_fields(8'($urandom), 5'($urandom), 4'($urandom), 8'($urandom),
                                  1'($urandom)));
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_buffer_loads();
        logic [7:0] fill;
        for (int i = 0; i < 16; i++) begin
            case (i)
                0:       fill = 8'h00;
                1:       fill = 8'hff;
                2:       fill = 8'h80;
                3:       fill = 8'h01;
                4:       fill = 8'hfe;
                default: fill = 8'($urandom);
            endcase
            send_item(ACT_LOAD, pack_fields(8'($urandom), 5'($urandom), i[3:0], fill,
                                            1'($urandom)));
        end
    endtask

    task automatic test_directed_transfers();
        write_half_period(8'd1);                        // short cells keep long transfers cheap
        run_transfer(ACT_WRITE, 8'h00, 5'd0, 0, 0);     // zero count: address only
        run_transfer(ACT_READ, 8'h00, 5'd31, 0, 0);     // R/W bit clear, count saturates at 16
        run_transfer(ACT_WRITE, 8'h3c, 5'd2, 100, 0);   // address NACK
        run_transfer(ACT_WRITE, 8'hff, 5'd3, 0, 100);   // R/W bit set, data NACK
        run_transfer(ACT_READ, 8'h81, 5'd1, 0, 0);      // error flag clears on start
    endtask

    task automatic test_half_period_extremes();
        write_half_period(8'd0);                        // high half behaves as one tick, low half as two
        run_transfer(ACT_WRITE, 8'h5a, 5'd1, 0, 0);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_half_period(8'd255);
        send_item(ACT_WRITE, pack_fields(8'h42, 5'd0, 4'($urandom), 8'($urandom),
                                         1'($urandom)));
        clock_bus(20, 0, 0);                            // START still far from its end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        write_half_period(8'd1);                        // counter already past: START ends
        clock_bus(BUS_TICKS_ALL, 0, 0);
    endtask

    task automatic test_random_traffic();
        logic [4:0] cnt;
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 3))
                0:       write_half_period(8'd1);
                1:       write_half_period(8'd2);
                2:       write_half_period(8'd3);
                default: write_half_period(HALF_PERIOD_RESET);
            endcase
            tx_idle_on = 1'($urandom_range(0, 1));
            rx_idle_on = 1'($urandom_range(0, 1));
            idle_traffic($urandom_range(0, 3));
            cnt = 5'($urandom_range(0, 2));
            run_transfer(($urandom_range(0, 1) != 0) ? ACT_READ : ACT_WRITE, 8'($urandom),
                         cnt, 4, 4);
        end
    endtask

    // ---------------- result side ----------------

    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = rx_idle_on ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk) m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result item with nothing pending");
                fail_count++;
            end else begin
                due = pending_results.pop_front();
                check_field("scl_out", 8'(due.scl), 8'(m_tdata[0]));
                check_field("sda_out", 8'(due.sda), 8'(m_tdata[1]));
                check_field("busy_res", 8'(due.busy), 8'(m_tdata[2]));
                check_field("nack_error", 8'(due.nack), 8'(m_tdata[3]));
                check_field("rx_byte", due.rx_byte, m_tdata[11:4]);
                check_field("rx_index", 8'(due.rx_index), 8'(m_tdata[15:12]));
                check_field("rx_valid", 8'(due.rx_valid), 8'(m_tuser[0]));
                check_field("done_res", 8'(due.done), 8'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
                    $display("i2c_master_byte_transfer test failed");
                    $finish;
                end
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = ACT_TICK;
        bus_phase = PH_IDLE;
        half_period = HALF_PERIOD_RESET;
        hold_ticks = '0;
        bits_done = '0;
        byte_pos = '0;
        bytes_rem = '0;
        shifter = '0;
        is_read = 1'b0;
        err_flag = 1'b0;
        scl_drv = 1'b1;
        sda_drv = 1'b1;
        repeat (12) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        test_buffer_loads();
        test_directed_transfers();
        test_half_period_extremes();
        test_random_traffic();

        wait_drained();
        repeat (4) @(posedge aclk);
        $display("%0d items: %0d transfers, %0d NACK aborts, %0d bytes read",
                 items_sent, transfers_begun, nack_aborts, bytes_read);
        $display("covered loads, saturated and empty counts, NACKs, half periods 0 to 255");
        if (fail_count == 0)
            $display("i2c_master_byte_transfer test passed");
        else
            $display("i2c_master_byte_transfer test failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/i2cm_pkg.sv
rtl/i2cm_ram.sv
rtl/i2c_master_byte_transfer.sv
sim/i2c_master_byte_transfer_test.sv
